// ----- rtl/core/rbgt_pkg.sv -----
`timescale 1ns / 1ps

package rbgt_pkg;

    // Bank size and time counter width
    localparam int CHANNELS  = 4;
    localparam int TIME_BITS = 32;
    localparam int CFG_BITS  = 32;
    localparam int CMP_BITS  = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
    localparam int MASK_BITS = 4;
    localparam int REGS      = 8;
    localparam int IDX_BITS  = $clog2(REGS);

    localparam logic [CFG_BITS-1:0] MAX_ON_RESET = CFG_BITS'(3000);

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CFG_BITS-1:0]  cfg_t;
    typedef logic [2:0]           req_t;
    typedef logic [2:0]           chan_t;
    typedef logic [1:0]           status_t;
    typedef logic [MASK_BITS-1:0] mask_t;

    // Request codes
    localparam req_t REQ_TICK    = 3'd0;
    localparam req_t REQ_ON      = 3'd1;
    localparam req_t REQ_OFF     = 3'd2;
    localparam req_t REQ_SET_ALL = 3'd3;

    // Status codes
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_BAD_CHAN  = 2'd1;
    localparam status_t ST_BUSY      = 2'd2;
    localparam status_t ST_BAD_CMD   = 2'd3;

    // Register indexes
    localparam logic [IDX_BITS-1:0] REG_MAX_ON_BASE  = IDX_BITS'(0);
    localparam logic [IDX_BITS-1:0] REG_MIN_OFF_BASE = IDX_BITS'(4);

    // Decoded item broadcast to every channel
    typedef struct packed {
        logic  fire;
        logic  tick;
        logic  set_all;
        logic  on_cmd;
        logic  off_cmd;
        logic  level;
        time_t time_now;
        time_t time_tick;
    } chan_ctrl_t;

endpackage

// ----- rtl/core/rbgt_if.sv -----
`timescale 1ns / 1ps

interface rbgt_req_if;
    logic                  valid;
    logic                  ready;
    rbgt_pkg::req_t        req_type;
    rbgt_pkg::chan_t       channel;
    logic                  level;

    modport source (output valid, output req_type, output channel, output level, input ready);
    modport sink   (input valid, input req_type, input channel, input level, output ready);
endinterface

interface rbgt_rsp_if;
    logic                  valid;
    logic                  ready;
    rbgt_pkg::status_t     status;
    rbgt_pkg::mask_t       channel_states;
    rbgt_pkg::mask_t       drive_levels;
    rbgt_pkg::mask_t       auto_off_mask;

    modport source (output valid, output status, output channel_states,
                    output drive_levels, output auto_off_mask, input ready);
    modport sink   (input valid, input status, input channel_states,
                    input drive_levels, input auto_off_mask, output ready);
endinterface

// ----- rtl/core/relay_bank_guarded_timer.sv -----
`timescale 1ns / 1ps

// Relay bank with guarded on/off timing.
// Items pass through the input register and then the result register, one item per cycle
// when not stalled; each item is decoded and applied to all channels in one pass.
// Reset: time counter, relay states and change stamps clear; maximum on times load 3000,
// minimum off times load 0. The input stalls only while both registers hold items and the
// result is not taken.

module relay_bank_guarded_timer (
    input  logic                                clk,
    input  logic                                rst_n,
    rbgt_req_if.sink                            req,
    rbgt_rsp_if.source                          rsp,
    input  logic                                cfg_we,
    input  logic [rbgt_pkg::IDX_BITS-1:0]       cfg_index,
    input  rbgt_pkg::cfg_t                      cfg_data
);

    localparam int CH = rbgt_pkg::CHANNELS;

    rbgt_pkg::cfg_t        max_on_reg  [CH];
    rbgt_pkg::cfg_t        min_off_reg [CH];
    rbgt_pkg::time_t       time_reg;

    logic                  in_valid_reg;
    rbgt_pkg::req_t        in_req_reg;
    rbgt_pkg::chan_t       in_chan_reg;
    logic                  in_level_reg;

    logic                  out_valid_reg;
    rbgt_pkg::status_t     status_reg;
    rbgt_pkg::mask_t       states_reg;
    rbgt_pkg::mask_t       auto_reg;

    logic                  advance;
    logic                  chan_ok;
    logic [1:0]            chan_idx;
    rbgt_pkg::chan_ctrl_t  ctrl;
    rbgt_pkg::status_t     status_next;
    rbgt_pkg::mask_t       states_next;
    rbgt_pkg::mask_t       auto_next;
    rbgt_pkg::mask_t       busy_vec;

    // Handshake: stage one moves on whenever the result register is empty or its result is taken
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH; i++)
            begin
                max_on_reg[i]  <= rbgt_pkg::MAX_ON_RESET;
                min_off_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < CH; i++)
            begin
                if (cfg_index == rbgt_pkg::REG_MAX_ON_BASE + rbgt_pkg::IDX_BITS'(i))
                    max_on_reg[i] <= cfg_data;
                if (cfg_index == rbgt_pkg::REG_MIN_OFF_BASE + rbgt_pkg::IDX_BITS'(i))
                    min_off_reg[i] <= cfg_data;
            end
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_req_reg   <= req.req_type;
            in_chan_reg  <= req.channel;
            in_level_reg <= req.level;
        end
    end

    // Decode the held item
    assign chan_ok  = (in_chan_reg >= 3'd1) && (in_chan_reg <= 3'(CH));
    assign chan_idx = 2'(in_chan_reg - 3'd1);

    always_comb
    begin
        ctrl.fire      = advance;
        ctrl.tick      = (in_req_reg == rbgt_pkg::REQ_TICK);
        ctrl.set_all   = (in_req_reg == rbgt_pkg::REQ_SET_ALL);
        ctrl.on_cmd    = (in_req_reg == rbgt_pkg::REQ_ON) && chan_ok;
        ctrl.off_cmd   = (in_req_reg == rbgt_pkg::REQ_OFF) && chan_ok;
        ctrl.level     = in_level_reg;
        ctrl.time_now  = time_reg;
        ctrl.time_tick = time_reg + rbgt_pkg::TIME_BITS'(1);
    end

    // Channel slices
    for (genvar g = 0; g < rbgt_pkg::MASK_BITS; g++)
    begin : g_chan
        if (g < CH)
        begin : g_present
            rbgt_chan u_chan (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .sel      (chan_idx == 2'(g)),
                .max_on   (max_on_reg[g]),
                .min_off  (min_off_reg[g]),
                .on_next  (states_next[g]),
                .busy     (busy_vec[g]),
                .auto_off (auto_next[g])
            );
        end
        else
        begin : g_absent
            assign states_next[g] = 1'b0;
            assign busy_vec[g]    = 1'b0;
            assign auto_next[g]   = 1'b0;
        end
    end

    // Status for the held item
    always_comb
    begin
        case (in_req_reg)
            rbgt_pkg::REQ_TICK,
            rbgt_pkg::REQ_SET_ALL: status_next = rbgt_pkg::ST_OK;
            rbgt_pkg::REQ_ON:
            begin
                if (!chan_ok)
                    status_next = rbgt_pkg::ST_BAD_CHAN;
                else if (busy_vec[chan_idx])
                    status_next = rbgt_pkg::ST_BUSY;
                else
                    status_next = rbgt_pkg::ST_OK;
            end
            rbgt_pkg::REQ_OFF:
                status_next = chan_ok ? rbgt_pkg::ST_OK : rbgt_pkg::ST_BAD_CHAN;
            default:
                status_next = chan_ok ? rbgt_pkg::ST_BAD_CMD : rbgt_pkg::ST_BAD_CHAN;
        endcase
    end

    // Advance time on ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_reg <= '0;
        else if (advance && ctrl.tick)
            time_reg <= ctrl.time_tick;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
            states_reg <= states_next;
            auto_reg   <= ctrl.tick ? auto_next : '0;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.channel_states = states_reg;
    assign rsp.drive_levels   = ~states_reg;
    assign rsp.auto_off_mask  = auto_reg;

endmodule

// ----- rtl/core/rbgt_chan.sv -----
`timescale 1ns / 1ps

module rbgt_chan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rbgt_pkg::chan_ctrl_t ctrl,
    input  logic                 sel,
    input  rbgt_pkg::cfg_t       max_on,
    input  rbgt_pkg::cfg_t       min_off,
    output logic                 on_next,
    output logic                 busy,
    output logic                 auto_off
);

    logic            on_reg;
    rbgt_pkg::time_t stamp_reg;
    rbgt_pkg::time_t stamp_next;
    rbgt_pkg::time_t dt_tick;
    rbgt_pkg::time_t dt_now;
    logic            guard_hit;

    // Elapsed times, wrapping
    assign dt_tick = ctrl.time_tick - stamp_reg;
    assign dt_now  = ctrl.time_now - stamp_reg;

    assign auto_off = ctrl.tick && on_reg && (max_on != '0)
                      && (rbgt_pkg::CMP_BITS'(dt_tick) >= rbgt_pkg::CMP_BITS'(max_on));

    assign guard_hit = !on_reg && (min_off != '0) && (stamp_reg != '0)
                       && (rbgt_pkg::CMP_BITS'(dt_now) < rbgt_pkg::CMP_BITS'(min_off));
    assign busy = guard_hit;

    // Next state for this channel
    always_comb
    begin
        on_next    = on_reg;
        stamp_next = stamp_reg;
        if (ctrl.tick)
        begin
            if (auto_off)
            begin
                on_next    = 1'b0;
                stamp_next = ctrl.time_tick;
            end
        end
        else if (ctrl.set_all)
        begin
            if (on_reg != ctrl.level)
            begin
                on_next    = ctrl.level;
                stamp_next = ctrl.time_now;
            end
        end
        else if (ctrl.on_cmd && sel)
        begin
            if (!guard_hit && !on_reg)
            begin
                on_next    = 1'b1;
                stamp_next = ctrl.time_now;
            end
        end
        else if (ctrl.off_cmd && sel)
        begin
            if (on_reg)
            begin
                on_next    = 1'b0;
                stamp_next = ctrl.time_now;
            end
        end
    end

    // Commit state when an item executes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg    <= 1'b0;
            stamp_reg <= '0;
        end
        else if (ctrl.fire)
        begin
            on_reg    <= on_next;
            stamp_reg <= stamp_next;
        end
    end

endmodule
